// File: design/udp_pf_pkg.sv
// ----------------------------------------------------------------------------
// udp_pf_pkg
// Shared types and constants for the UDP port parity packet filter.
// ----------------------------------------------------------------------------
package udp_pf_pkg;

  localparam logic [7:0]  ETH_HDR_LEN    = 8'd14;
  localparam logic [7:0]  IP_END_MIN     = 8'd34;   // ethernet + minimum ipv4
  localparam logic [7:0]  UDP_HDR_LEN    = 8'd8;
  localparam logic [7:0]  PAYLOAD_MIN    = 8'd4;
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [6:0]  COUNT_MAX      = 7'd127;
  localparam logic [15:0] WATCH_PORT_RST = 16'd7000;

  // byte offsets inside the frame
  localparam logic [6:0]  POS_ETYPE_HI   = 7'd12;
  localparam logic [6:0]  POS_ETYPE_LO   = 7'd13;
  localparam logic [6:0]  POS_IHL        = 7'd14;
  localparam logic [6:0]  POS_PROTO      = 7'd23;
  localparam logic [6:0]  POS_UDP_MIN    = 7'd16;

  typedef enum logic [3:0] {
    RSN_SHORT_ETH     = 4'd0,
    RSN_NOT_IPV4      = 4'd1,
    RSN_SHORT_IP      = 4'd2,
    RSN_SHORT_OPTIONS = 4'd3,
    RSN_NOT_UDP       = 4'd4,
    RSN_SHORT_UDP     = 4'd5,
    RSN_OTHER_PORT    = 4'd6,
    RSN_SHORT_PAYLOAD = 4'd7,
    RSN_ODD           = 4'd8,
    RSN_EVEN          = 4'd9
  } reason_t;

  // header fields as seen after the current byte is captured
  typedef struct packed {
    logic [6:0]  pos;
    logic [15:0] ether_type;
    logic [3:0]  header_words;
    logic [7:0]  ip_protocol;
    logic [15:0] dest_port;
    logic        payload_low_bit;
  } frame_fields_t;

  // first byte of the udp header
  function automatic logic [6:0] udp_start(input logic [3:0] hw);
    udp_start = 7'd14 + {1'b0, hw, 2'b00};
  endfunction

endpackage

// File: design/udp_pf_parser.sv
// ----------------------------------------------------------------------------
// udp_pf_parser
// Byte counter and header field capture for one frame at a time.
// ----------------------------------------------------------------------------
module udp_pf_parser (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [7:0]               byte_i,
  input  logic                     last_i,
  input  logic                     advance_i,
  output udp_pf_pkg::frame_fields_t fields_o
);

  logic [6:0]  count_r, count_nxt;
  logic [15:0] etype_r, etype_nxt;
  logic [3:0]  hw_r, hw_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [15:0] dport_r, dport_nxt;
  logic        plb_r, plb_nxt;
  logic [6:0]  ustart;
  logic        past_ip;

  // the udp offsets can only match from offset 16 on, so the old ihl serves
  assign ustart  = udp_pf_pkg::udp_start(hw_r);
  assign past_ip = (count_r >= udp_pf_pkg::POS_UDP_MIN);

  always_comb begin
    etype_nxt = etype_r;
    hw_nxt    = hw_r;
    proto_nxt = proto_r;
    dport_nxt = dport_r;
    plb_nxt   = plb_r;
    if (count_r == udp_pf_pkg::POS_ETYPE_HI) etype_nxt[15:8] = byte_i;
    if (count_r == udp_pf_pkg::POS_ETYPE_LO) etype_nxt[7:0]  = byte_i;
    if (count_r == udp_pf_pkg::POS_IHL)      hw_nxt          = byte_i[3:0];
    if (count_r == udp_pf_pkg::POS_PROTO)    proto_nxt       = byte_i;
    if (past_ip && count_r == ustart + 7'd2) dport_nxt[15:8] = byte_i;
    if (past_ip && count_r == ustart + 7'd3) dport_nxt[7:0]  = byte_i;
    if (past_ip && count_r == ustart + 7'd8) plb_nxt         = byte_i[0];
    count_nxt = (count_r == udp_pf_pkg::COUNT_MAX) ? count_r : count_r + 7'd1;
  end

  always_comb begin
    fields_o.pos             = count_r;
    fields_o.ether_type      = etype_nxt;
    fields_o.header_words    = hw_nxt;
    fields_o.ip_protocol     = proto_nxt;
    fields_o.dest_port       = dport_nxt;
    fields_o.payload_low_bit = plb_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      etype_r <= '0;
      hw_r    <= '0;
      proto_r <= '0;
      dport_r <= '0;
      plb_r   <= 1'b0;
    end else if (advance_i) begin
      if (last_i) begin
        // frame done, start clean
        count_r <= '0;
        etype_r <= '0;
        hw_r    <= '0;
        proto_r <= '0;
        dport_r <= '0;
        plb_r   <= 1'b0;
      end else begin
        count_r <= count_nxt;
        etype_r <= etype_nxt;
        hw_r    <= hw_nxt;
        proto_r <= proto_nxt;
        dport_r <= dport_nxt;
        plb_r   <= plb_nxt;
      end
    end
  end

endmodule

// File: design/udp_pf_verdict.sv
// ----------------------------------------------------------------------------
// udp_pf_verdict
// End-of-frame checks in priority order, giving drop and reason.
// ----------------------------------------------------------------------------
module udp_pf_verdict (
  input  udp_pf_pkg::frame_fields_t fields_i,
  input  logic [15:0]               watch_port_i,
  output logic                      drop_o,
  output udp_pf_pkg::reason_t       reason_o
);

  logic [7:0] len;
  logic [7:0] ustart;

  assign len    = {1'b0, fields_i.pos} + 8'd1;
  assign ustart = {1'b0, udp_pf_pkg::udp_start(fields_i.header_words)};

  always_comb begin
    priority if (len < udp_pf_pkg::ETH_HDR_LEN) begin
      reason_o = udp_pf_pkg::RSN_SHORT_ETH;
    end else if (fields_i.ether_type != udp_pf_pkg::ETHERTYPE_IPV4) begin
      reason_o = udp_pf_pkg::RSN_NOT_IPV4;
    end else if (len < udp_pf_pkg::IP_END_MIN) begin
      reason_o = udp_pf_pkg::RSN_SHORT_IP;
    end else if (len < ustart) begin
      reason_o = udp_pf_pkg::RSN_SHORT_OPTIONS;
    end else if (fields_i.ip_protocol != udp_pf_pkg::PROTO_UDP) begin
      reason_o = udp_pf_pkg::RSN_NOT_UDP;
    end else if (len < ustart + udp_pf_pkg::UDP_HDR_LEN) begin
      reason_o = udp_pf_pkg::RSN_SHORT_UDP;
    end else if (fields_i.dest_port != watch_port_i) begin
      reason_o = udp_pf_pkg::RSN_OTHER_PORT;
    end else if (len < ustart + udp_pf_pkg::UDP_HDR_LEN + udp_pf_pkg::PAYLOAD_MIN) begin
      reason_o = udp_pf_pkg::RSN_SHORT_PAYLOAD;
    end else if (fields_i.payload_low_bit) begin
      reason_o = udp_pf_pkg::RSN_ODD;
    end else begin
      reason_o = udp_pf_pkg::RSN_EVEN;
    end
  end

  assign drop_o = (reason_o == udp_pf_pkg::RSN_EVEN);

endmodule

// File: design/udp_pf_core_top.sv
// ----------------------------------------------------------------------------
// udp_port_parity_packet_filter_core
// Ethernet/IPv4/UDP header parser with a per-port payload parity filter.
// ----------------------------------------------------------------------------
// Usage: frame bytes enter one per clock on the in_ channel, starting at the
// destination MAC, with in_last on the final byte. The block takes a byte in
// every cycle when not stalled; a byte sits in the input register, where the
// counter and field capture see it, and the verdict for a final byte lands in
// the result register, raising out_valid, as the byte leaves the input register.
// Only the result register can stall the input: a final byte waits while an
// earlier verdict has not been taken. The watched port (reset 7000) is written
// through cfg_ and must only change between frames.
module udp_port_parity_packet_filter_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_watch_port,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_drop,
  output logic [3:0]  out_reason
);

  logic [15:0] watch_port_r;
  logic        s1_valid_r, s1_valid_nxt;
  logic [7:0]  s1_byte_r;
  logic        s1_last_r;
  logic        advance;
  logic        out_valid_r, out_valid_nxt;
  logic        out_drop_r;
  udp_pf_pkg::reason_t out_reason_r;

  udp_pf_pkg::frame_fields_t fields;
  logic                      v_drop;
  udp_pf_pkg::reason_t       v_reason;

  assign cfg_ready = 1'b1;

  // a non-final byte always moves on; a final one needs room for its verdict
  assign advance  = s1_valid_r && (!s1_last_r || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  assign s1_valid_nxt  = in_ready ? in_valid : s1_valid_r;
  assign out_valid_nxt = (advance && s1_last_r) ? 1'b1 :
                         (out_ready ? 1'b0 : out_valid_r);

  udp_pf_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_i    (s1_byte_r),
    .last_i    (s1_last_r),
    .advance_i (advance),
    .fields_o  (fields)
  );

  udp_pf_verdict u_verdict (
    .fields_i     (fields),
    .watch_port_i (watch_port_r),
    .drop_o       (v_drop),
    .reason_o     (v_reason)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      watch_port_r <= udp_pf_pkg::WATCH_PORT_RST;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) watch_port_r <= cfg_watch_port;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_last;
    end
    if (advance && s1_last_r) begin
      out_drop_r   <= v_drop;
      out_reason_r <= v_reason;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_drop   = out_drop_r;
  assign out_reason = out_reason_r;

  // a finished verdict must reach the result register
  assert property (@(posedge clk) disable iff (!rst_n)
    advance && s1_last_r |=> out_valid_r)
    else $error("verdict lost on final word");

  // a waiting verdict is never overwritten or dropped
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(out_reason_r))
    else $error("pending verdict disturbed");

  // input only stalls behind a final word blocked by the result register
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid_r && s1_last_r && out_valid_r && !out_ready)
    else $error("unexpected input stall");

  // drop only comes with the even-payload reason
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_drop_r |-> out_reason_r == udp_pf_pkg::RSN_EVEN)
    else $error("drop without even reason");

endmodule

// File: sim/udp_port_parity_packet_filter_core_tb.sv
// ----------------------------------------------------------------------------
// udp_port_parity_packet_filter_core_tb
// Streams Ethernet frames byte by byte through the filter and checks each
// drop/reason verdict against a table entry or the bench's header parser. A
// table of hand-built frames walks every reason code first; then phases of
// random frames, mostly well-formed IPv4/UDP around the length boundaries,
// run under several watched ports with random idling on both channels.
// ----------------------------------------------------------------------------
module udp_port_parity_packet_filter_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ETH_BYTES   = 14;
  localparam int IP_END      = 34;
  localparam int UDP_BYTES   = 8;
  localparam int MIN_PAYLOAD = 4;
  localparam int OFS_ETYPE   = 12;
  localparam int OFS_IHL     = 14;
  localparam int OFS_PROTO   = 23;
  localparam int OFS_UDP_MIN = 16;
  localparam logic [15:0] PORT_7000 = 16'd7000;
  localparam logic TYPED   = 1'b1;
  localparam logic PREDICT = 1'b0;

  typedef enum logic [1:0] {FILL_ZERO, FILL_ONES, FILL_RAND} fill_t;

  typedef struct packed {
    logic                drop;
    udp_pf_pkg::reason_t reason;
  } verdict_t;

  typedef struct packed {
    logic [6:0]  count;
    logic [15:0] etype;
    logic [3:0]  words;
    logic [7:0]  proto;
    logic [15:0] dport;
    logic        pay_lsb;
  } parse_state_t;

  typedef struct packed {
    logic [7:0]          len;
    logic [15:0]         etype;
    logic [7:0]          ver_ihl;
    logic [7:0]          proto;
    logic [15:0]         dport;
    logic [7:0]          payload;
    fill_t               fill;
    logic                typed;
    logic                drop;
    udp_pf_pkg::reason_t reason;
  } frame_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_watch_port = 16'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'd0;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_drop;
  logic [3:0]  out_reason;

  parse_state_t parse_st = '0;
  logic [15:0]  filter_port = udp_pf_pkg::WATCH_PORT_RST;
  verdict_t     verdicts_due[$];
  logic [7:0]   frame_bytes[$];
  int           errors = 0;
  int           sent_bytes = 0;
  bit           rx_hold_req = 1'b0;

  // hand-built frames; the watched port is still at its reset value here
  frame_row_t dir_rows [20] = '{
    '{8'd1,   16'h0000, 8'h00, 8'h00, 16'h0000, 8'h00, FILL_ZERO, TYPED, 1'b0,
      udp_pf_pkg::RSN_SHORT_ETH},
    '{8'd13,  16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF, FILL_ONES, TYPED, 1'b0,
      udp_pf_pkg::RSN_SHORT_ETH},
    '{8'd14,  16'h0800, 8'h45, 8'd17, PORT_7000, 8'h00, FILL_ZERO, TYPED, 1'b0,
      udp_pf_pkg::RSN_SHORT_IP},
    '{8'd20,  16'h86DD, 8'h45, 8'd17, PORT_7000, 8'h00, FILL_RAND, TYPED, 1'b0,
      udp_pf_pkg::RSN_NOT_IPV4},
    '{8'd20,  16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF, FILL_ONES, TYPED, 1'b0,
      udp_pf_pkg::RSN_NOT_IPV4},
    '{8'd33,  16'h0800, 8'h45, 8'd17, PORT_7000, 8'h00, FILL_RAND, TYPED, 1'b0,
      udp_pf_pkg::RSN_SHORT_IP},
    '{8'd34,  16'h0800, 8'h4F, 8'd17, PORT_7000, 8'h00, FILL_ZERO, TYPED, 1'b0,
      udp_pf_pkg::RSN_SHORT_OPTIONS},
    '{8'd73,  16'h0800, 8'h4F, 8'd17, PORT_7000, 8'h00, FILL_RAND, TYPED, 1'b0,
      udp_pf_pkg::RSN_SHORT_OPTIONS},
    '{8'd34,  16'h0800, 8'h45, 8'd6,  PORT_7000, 8'h00, FILL_RAND, TYPED, 1'b0,
      udp_pf_pkg::RSN_NOT_UDP},
    '{8'd41,  16'h0800, 8'h45, 8'd17, PORT_7000, 8'h00, FILL_ZERO, TYPED, 1'b0,
      udp_pf_pkg::RSN_SHORT_UDP},
    '{8'd42,  16'h0800, 8'h45, 8'd17, 16'd7001, 8'h00, FILL_RAND, TYPED, 1'b0,
      udp_pf_pkg::RSN_OTHER_PORT},
    '{8'd45,  16'h0800, 8'h45, 8'd17, PORT_7000, 8'h00, FILL_RAND, TYPED, 1'b0,
      udp_pf_pkg::RSN_SHORT_PAYLOAD},
    '{8'd46,  16'h0800, 8'h45, 8'd17, PORT_7000, 8'h01, FILL_ZERO, TYPED, 1'b0,
      udp_pf_pkg::RSN_ODD},
    '{8'd46,  16'h0800, 8'h45, 8'd17, PORT_7000, 8'hFE, FILL_ONES, TYPED, 1'b1,
      udp_pf_pkg::RSN_EVEN},
    // unusual ihl values; below five, the udp header overlaps the ip header
    '{8'd60,  16'h0800, 8'h40, 8'd17, PORT_7000, 8'h00, FILL_RAND, PREDICT, 1'b0,
      udp_pf_pkg::RSN_SHORT_ETH},
    '{8'd40,  16'h0800, 8'h42, 8'd17, PORT_7000, 8'h01, FILL_RAND, PREDICT, 1'b0,
      udp_pf_pkg::RSN_SHORT_ETH},
    '{8'd90,  16'h0800, 8'h4F, 8'd17, PORT_7000, 8'hFF, FILL_RAND, PREDICT, 1'b0,
      udp_pf_pkg::RSN_SHORT_ETH},
    // long frames near and past the byte counter's saturation point
    '{8'd140, 16'h0800, 8'h46, 8'd17, PORT_7000, 8'h00, FILL_ONES, PREDICT, 1'b0,
      udp_pf_pkg::RSN_SHORT_ETH},
    '{8'd127, 16'h0800, 8'h45, 8'd17, PORT_7000, 8'h02, FILL_RAND, PREDICT, 1'b0,
      udp_pf_pkg::RSN_SHORT_ETH},
    '{8'd128, 16'h0800, 8'h45, 8'd17, PORT_7000, 8'h03, FILL_RAND, PREDICT, 1'b0,
      udp_pf_pkg::RSN_SHORT_ETH}
  };

  udp_port_parity_packet_filter_core u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_watch_port (cfg_watch_port),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_byte   (in_data_byte),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_drop       (out_drop),
    .out_reason     (out_reason)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("udp_port_parity_packet_filter_core_tb: errors");
    $finish;
  end

  // parse one accepted byte; a final byte yields the verdict and clears the frame
  function automatic void parse_byte(input logic [7:0] b, input logic fin, output bit got,
                                     output verdict_t v);
    int                  pos;
    int                  ustart;
    int                  len;
    udp_pf_pkg::reason_t r;
    pos = int'(parse_st.count);
    ustart = ETH_BYTES + 4 * int'(parse_st.words);
    got = fin;
    v = '{1'b0, udp_pf_pkg::RSN_SHORT_ETH};
    if (pos == OFS_ETYPE) parse_st.etype[15:8] = b;
    if (pos == OFS_ETYPE + 1) parse_st.etype[7:0] = b;
    if (pos == OFS_IHL) begin
      parse_st.words = b[3:0];
      ustart = ETH_BYTES + 4 * int'(parse_st.words);
    end
    if (pos == OFS_PROTO) parse_st.proto = b;
    if (pos >= OFS_UDP_MIN && pos == ustart + 2) parse_st.dport[15:8] = b;
    if (pos >= OFS_UDP_MIN && pos == ustart + 3) parse_st.dport[7:0] = b;
    if (pos >= OFS_UDP_MIN && pos == ustart + UDP_BYTES) parse_st.pay_lsb = b[0];
    if (!fin) begin
      if (parse_st.count != 7'd127) parse_st.count = parse_st.count + 7'd1;
      return;
    end
    len = pos + 1;
    if (len < ETH_BYTES) r = udp_pf_pkg::RSN_SHORT_ETH;
    else if (parse_st.etype != udp_pf_pkg::ETHERTYPE_IPV4) r = udp_pf_pkg::RSN_NOT_IPV4;
    else if (len < IP_END) r = udp_pf_pkg::RSN_SHORT_IP;
    else if (len < ustart) r = udp_pf_pkg::RSN_SHORT_OPTIONS;
    else if (parse_st.proto != udp_pf_pkg::PROTO_UDP) r = udp_pf_pkg::RSN_NOT_UDP;
    else if (len < ustart + UDP_BYTES) r = udp_pf_pkg::RSN_SHORT_UDP;
    else if (parse_st.dport != filter_port) r = udp_pf_pkg::RSN_OTHER_PORT;
    else if (len < ustart + UDP_BYTES + MIN_PAYLOAD) r = udp_pf_pkg::RSN_SHORT_PAYLOAD;
    else r = parse_st.pay_lsb ? udp_pf_pkg::RSN_ODD : udp_pf_pkg::RSN_EVEN;
    v.drop = (r == udp_pf_pkg::RSN_EVEN);
    v.reason = r;
    parse_st = '0;
  endfunction

  function automatic void load_frame(input int len, input logic [15:0] et,
                                     input logic [7:0] vihl, input logic [7:0] pr,
                                     input logic [15:0] dp, input logic [7:0] pay,
                                     input fill_t fill);
    int i;
    int ustart;
    frame_bytes.delete();
    for (i = 0; i < len; i++) begin
      case (fill)
        FILL_ZERO: frame_bytes.push_back(8'h00);
        FILL_ONES: frame_bytes.push_back(8'hFF);
        default:   frame_bytes.push_back(8'($urandom_range(0, 255)));
      endcase
    end
    ustart = ETH_BYTES + 4 * int'(vihl[3:0]);
    if (OFS_ETYPE < len) frame_bytes[OFS_ETYPE] = et[15:8];
    if (OFS_ETYPE + 1 < len) frame_bytes[OFS_ETYPE + 1] = et[7:0];
    if (OFS_IHL < len) frame_bytes[OFS_IHL] = vihl;
    if (OFS_PROTO < len) frame_bytes[OFS_PROTO] = pr;
    if (ustart + 2 < len) frame_bytes[ustart + 2] = dp[15:8];
    if (ustart + 3 < len) frame_bytes[ustart + 3] = dp[7:0];
    if (ustart + UDP_BYTES < len) frame_bytes[ustart + UDP_BYTES] = pay;
  endfunction

  // mostly well-formed udp frames near the length boundaries, some noise
  function automatic void load_random_frame();
    int          kind;
    int          ustart;
    int          len;
    logic [7:0]  vihl;
    logic [7:0]  pr;
    logic [15:0] et;
    logic [15:0] dp;
    kind = $urandom_range(0, 15);
    vihl = 8'h45;
    et = udp_pf_pkg::ETHERTYPE_IPV4;
    pr = udp_pf_pkg::PROTO_UDP;
    dp = filter_port;
    if ($urandom_range(0, 3) == 0) vihl[3:0] = 4'($urandom_range(0, 15));
    if ($urandom_range(0, 7) == 0) vihl[7:4] = 4'($urandom_range(0, 15));
    if ($urandom_range(0, 11) == 0) et = 16'($urandom_range(0, 65535));
    if ($urandom_range(0, 11) == 0) pr = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 7))
      0: dp = 16'($urandom_range(0, 65535));
      1: dp = filter_port ^ (16'h0001 << $urandom_range(0, 15));
      default: ;
    endcase
    ustart = ETH_BYTES + 4 * int'(vihl[3:0]);
    if (kind == 0) begin
      len = $urandom_range(1, 80);
      vihl = 8'($urandom_range(0, 255));
      et = 16'($urandom_range(0, 65535));
      pr = 8'($urandom_range(0, 255));
    end else if (kind == 1) begin
      len = $urandom_range(120, 200);
    end else begin
      len = ustart + UDP_BYTES + MIN_PAYLOAD + $urandom_range(0, 6) - $urandom_range(0, 16);
    end
    if (len < 1) len = 1;
    load_frame(len, et, vihl, pr, dp, 8'($urandom_range(0, 255)), FILL_RAND);
  endfunction

  task automatic send_frame(input logic typed, input verdict_t typed_v);
    int       i;
    int       gap;
    int       pace;
    bit       got;
    verdict_t v;
    pace = $urandom_range(0, 3);
    for (i = 0; i < frame_bytes.size(); i++) begin
      in_valid <= 1'b1;
      in_data_byte <= frame_bytes[i];
      in_last <= (i == frame_bytes.size() - 1);
      do @(posedge clk); while (!in_ready);
      parse_byte(frame_bytes[i], i == frame_bytes.size() - 1, got, v);
      sent_bytes++;
      if (got) verdicts_due.push_back(typed ? typed_v : v);
      gap = 0;
      case (pace)
        1: if ($urandom_range(0, 3) == 0) gap = $urandom_range(1, 2);
        2: if ($urandom_range(0, 1) == 0) gap = $urandom_range(1, 4);
        3: if ($urandom_range(0, 15) == 0) gap = $urandom_range(8, 40);
        default: ;
      endcase
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // hold the input until every verdict is in, then let the pipe empty
  task automatic settle_results();
    int waited;
    in_valid <= 1'b0;
    waited = 0;
    while (verdicts_due.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (6) @(posedge clk);
    if (verdicts_due.size() != 0) begin
      $display("%0t: %0d verdicts expected but never came", $time, verdicts_due.size());
      errors += verdicts_due.size();
      verdicts_due.delete();
    end
  endtask

  task automatic write_target(input logic [15:0] port);
    cfg_valid <= 1'b1;
    cfg_watch_port <= port;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    filter_port = port;
  endtask

  initial begin : result_sink
    int run_left;
    int pace;
    run_left = 0;
    pace = 0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      if (run_left == 0) begin
        pace = $urandom_range(0, 3);
        run_left = $urandom_range(10, 120);
      end
      run_left--;
      case (pace)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= ($urandom_range(0, 7) != 0);
        default: out_ready <= ($urandom_range(0, 15) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    verdict_t head;
    if (rst_n && out_valid && out_ready) begin
      if (verdicts_due.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual drop %0b reason %0d",
                 $time, out_drop, out_reason);
        errors++;
      end else begin
        head = verdicts_due.pop_front();
        if (out_drop !== head.drop) begin
          $display("%0t: drop mismatch, expected %0b actual %0b", $time, head.drop, out_drop);
          errors++;
        end
        if (out_reason !== head.reason) begin
          $display("%0t: reason mismatch, expected %0d actual %0d",
                   $time, head.reason, out_reason);
          errors++;
        end
      end
    end
  end

  initial begin : stimulus
    int          r;
    int          ph;
    int          start_bytes;
    int          frames;
    logic [15:0] port;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (r = 0; r < $size(dir_rows); r++) begin
      load_frame(int'(dir_rows[r].len), dir_rows[r].etype, dir_rows[r].ver_ihl,
                 dir_rows[r].proto, dir_rows[r].dport, dir_rows[r].payload, dir_rows[r].fill);
      send_frame(dir_rows[r].typed, '{dir_rows[r].drop, dir_rows[r].reason});
    end
    settle_results();

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: port = 16'h0000;
        1: port = 16'hFFFF;
        2: port = 16'($urandom_range(1, 65534));
        default: port = PORT_7000;
      endcase
      write_target(port);
      // sink stalls for a long stretch while frames keep coming
      if (ph == 1) rx_hold_req = 1'b1;
      start_bytes = sent_bytes;
      frames = 0;
      while (sent_bytes - start_bytes < 30 || frames < 2) begin
        load_random_frame();
        send_frame(PREDICT, '0);
        frames++;
      end
      settle_results();
    end

    if (errors == 0) begin
      $display("udp_port_parity_packet_filter_core_tb: clean");
    end else begin
      $display("udp_port_parity_packet_filter_core_tb: errors");
    end
    $finish;
  end

endmodule
